### src/lbsg_pkg.sv
// ----------------------------------------------------------------------------
// lbsg_pkg: shared types, constants and table builders
// Holds the job format passed from the front to the back, the fixed widths of
// the level datapath, and the elaboration-time builders for the band tables.
// ----------------------------------------------------------------------------
package lbsg_pkg;

	localparam int BAND_W = 6;
	localparam int MAG_W = 16;
	localparam int SUM_W = 27;
	localparam int INV_W = 16;
	localparam int EDGE_W = 11;
	localparam int LEVEL_W = 10;
	localparam int PROD_W = SUM_W + INV_W;
	localparam int RAD_W = 60;
	localparam int ROOT_W = 30;
	localparam int REM_W = 32;
	localparam int T_W = 42;
	localparam int Q_W = 18;
	localparam int CNT_W = 5;
	localparam int ROOT_STEPS = 30;
	localparam int JOB_DEPTH = 4;
	localparam logic [T_W-1:0] FOUR_D = T_W'(20 * (64'd1 << 24));
	localparam logic [15:0] RECIP_5 = 16'd52429;
	localparam logic [Q_W-1:0] SAT_Q = Q_W'(1285);

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [SUM_W-1:0]  sum;
		logic [INV_W-1:0]  inv;
		logic              last;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ROOT,
		BK_SCALE,
		BK_EMIT
	} back_state_t;

	typedef logic [63:0][EDGE_W-1:0] edge_tab_t;
	typedef logic [63:0][INV_W-1:0] inv_tab_t;

	function automatic logic pow_fits(int unsigned m, int unsigned q, int unsigned p);
		logic [703:0] v;
		logic [703:0] lim;
		v = 704'd1;
		for (int unsigned i = 0; i < q; i++) begin
			v = v * 704'(m);
		end
		lim = 704'd1 << p;
		return v <= lim;
	endfunction

	function automatic logic [63:0] log2_q32(int unsigned v);
		int unsigned k;
		logic [63:0] y;
		logic [63:0] r;
		k = 0;
		while (k < 31 && (v >> (k + 1)) != 0) begin
			k++;
		end
		y = (64'(v) << 31) >> k;
		r = 64'(k) << 32;
		for (int b = 31; b >= 0; b--) begin
			y = (y * y) >> 31;
			if (y >= 64'h1_0000_0000) begin
				y = y >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic edge_tab_t build_edges(int unsigned band_count, int unsigned bin_count);
		edge_tab_t t;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned prev;
		t = '0;
		prev = 0;
		for (int unsigned x = 0; x < 64; x++) begin
			if (x < band_count) begin
				lo = 1;
				hi = 1024;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (pow_fits(mid, band_count - 1, 10 * x))
						lo = mid;
					else
						hi = mid - 1;
				end
				if (lo > bin_count - 1)
					lo = bin_count - 1;
				if (lo <= prev)
					lo = prev + 1;
				t[x] = EDGE_W'(lo);
				prev = lo;
			end
		end
		return t;
	endfunction

	// The factor of a band follows from its bin count, which is fixed by the
	// edges and by the frame end.
	function automatic inv_tab_t build_inv(int unsigned band_count, int unsigned bin_count);
		inv_tab_t t;
		edge_tab_t e;
		logic [63:0] l10;
		logic [63:0] ls;
		int unsigned prev;
		int unsigned top;
		int unsigned cnt;
		t = '0;
		e = build_edges(band_count, bin_count);
		l10 = log2_q32(10);
		for (int unsigned b = 0; b < 64; b++) begin
			if (b < band_count) begin
				prev = (b == 0) ? 0 : int'(e[b-1]);
				top = (int'(e[b]) > bin_count - 1) ? bin_count - 1 : int'(e[b]);
				cnt = (top > prev) ? top - prev : 1;
				ls = log2_q32(10 + cnt);
				t[b] = INV_W'(udiv64((l10 << 16) + (ls >> 1), ls));
			end
		end
		return t;
	endfunction

endpackage

### src/log_band_spectrum_grouper_core.sv
// ----------------------------------------------------------------------------
// log_band_spectrum_grouper_core: log-spaced band grouper for FFT magnitudes
// Sums one frame of FFT bins into log-spaced bands and reports a level per
// band, the last band of a frame being marked.
// ----------------------------------------------------------------------------
// Bins enter on push/full, one per transfer, bin 0 first; bin 0 is dropped.
// A transfer is taken at every clock edge with push high and full low.
// Results leave on empty/pop: while empty is low the oldest band result sits
// on band_number, band_level and final_band, and pop takes it.
// Bins that do not close a band are taken at one per cycle while full is low.
// A bin that closes a band posts a job to a four-entry queue; the level unit
// handles one band at a time, paced by its square root that resolves one bit a cycle.
// A band's job passes from the queue through the MUL, ROOT, SCALE and EMIT steps.
// full rises while the queue holds four jobs, so a run of narrow bands
// limits intake to the pace of the level unit once the queue has filled.
// When pop stays low, one finished result waits in the output register and
// the level unit holds its next result until it is taken.
// Reset empties the queue and the output and restarts at bin 0 of a frame.
// ----------------------------------------------------------------------------
module log_band_spectrum_grouper_core #(
	parameter int BAND_COUNT = 28,
	parameter int BIN_COUNT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [lbsg_pkg::MAG_W-1:0]          bin_magnitude,
	output logic                                empty,
	input  logic                                pop,
	output logic [lbsg_pkg::BAND_W-1:0]         band_number,
	output logic signed [lbsg_pkg::LEVEL_W-1:0] band_level,
	output logic                                final_band
);

	logic           job_full;
	logic           job_empty;
	logic           job_push;
	logic           job_pop;
	lbsg_pkg::job_t job_in;
	lbsg_pkg::job_t job_out;

	lbsg_front #(
		.BAND_COUNT(BAND_COUNT),
		.BIN_COUNT(BIN_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.bin_magnitude(bin_magnitude),
		.full(full),
		.job_full(job_full),
		.job_push(job_push),
		.job_data(job_in)
	);

	lbsg_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_data(job_in),
		.full(job_full),
		.rd_en(job_pop),
		.rd_data(job_out),
		.empty(job_empty)
	);

	lbsg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_empty(job_empty),
		.job_data(job_out),
		.job_pop(job_pop),
		.pop(pop),
		.empty(empty),
		.band_number(band_number),
		.band_level(band_level),
		.final_band(final_band)
	);

endmodule

### src/lbsg_front.sv
// ----------------------------------------------------------------------------
// lbsg_front: bin intake and band accumulation
// Tracks the bin position and the open band, sums the magnitudes with
// saturation, and posts one job to the queue each time a band closes.
// ----------------------------------------------------------------------------
module lbsg_front #(
	parameter int BAND_COUNT = 28,
	parameter int BIN_COUNT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [lbsg_pkg::MAG_W-1:0]  bin_magnitude,
	output logic                        full,
	input  logic                        job_full,
	output logic                        job_push,
	output lbsg_pkg::job_t              job_data
);

	localparam int POS_W = $clog2(BIN_COUNT);
	localparam lbsg_pkg::edge_tab_t EDGES = lbsg_pkg::build_edges(BAND_COUNT, BIN_COUNT);
	localparam lbsg_pkg::inv_tab_t INVS = lbsg_pkg::build_inv(BAND_COUNT, BIN_COUNT);

	logic [POS_W-1:0]           pos_q;
	logic [lbsg_pkg::BAND_W-1:0] band_q;
	logic [lbsg_pkg::SUM_W-1:0]  sum_q;

	logic                        accept;
	logic [lbsg_pkg::SUM_W:0]    sum_wide;
	logic [lbsg_pkg::SUM_W-1:0]  sum_next;
	logic                        last_bin;
	logic                        last_band;
	logic                        close;

	always_comb begin
		accept = push && !job_full;
		sum_wide = {1'b0, sum_q} + (lbsg_pkg::SUM_W + 1)'(bin_magnitude);
		sum_next = sum_wide[lbsg_pkg::SUM_W] ? '1 : sum_wide[lbsg_pkg::SUM_W-1:0];
		last_bin = pos_q >= POS_W'(BIN_COUNT - 1);
		last_band = band_q >= lbsg_pkg::BAND_W'(BAND_COUNT - 1);
		close = (lbsg_pkg::EDGE_W'(pos_q) == EDGES[band_q]) || last_bin;
		job_push = accept && (pos_q != '0) && close;
		job_data.band = band_q;
		job_data.sum = sum_next;
		job_data.inv = INVS[band_q];
		job_data.last = last_bin || last_band;
	end

	assign full = job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			band_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (pos_q == '0) begin
				pos_q <= POS_W'(1);
			end else if (!close) begin
				sum_q <= sum_next;
				pos_q <= pos_q + POS_W'(1);
			end else begin
				sum_q <= '0;
				if (last_bin || last_band) begin
					pos_q <= '0;
					band_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					band_q <= band_q + lbsg_pkg::BAND_W'(1);
				end
			end
		end
	end

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(BIN_COUNT - 1))
		else $error("Bin position ran past the end of the frame.");

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		job_push && job_data.last |=> pos_q == '0 && band_q == '0 && sum_q == '0)
		else $error("A final band did not restart the frame.");

endmodule

### src/lbsg_job_fifo.sv
// ----------------------------------------------------------------------------
// lbsg_job_fifo: short job queue between front and back
// A small register queue of closed-band jobs, so that the intake and the
// level computation stall independently.
// ----------------------------------------------------------------------------
module lbsg_job_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  lbsg_pkg::job_t  wr_data,
	output logic            full,
	input  logic            rd_en,
	output lbsg_pkg::job_t  rd_data,
	output logic            empty
);

	localparam int PTR_W = $clog2(lbsg_pkg::JOB_DEPTH);

	lbsg_pkg::job_t   mem_q [lbsg_pkg::JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full = count_q == (PTR_W + 1)'(lbsg_pkg::JOB_DEPTH);
	assign empty = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en |-> !full) and (rd_en |-> !empty))
		else $error("Job queue written while full or read while empty.");

endmodule

### src/lbsg_back.sv
// ----------------------------------------------------------------------------
// lbsg_back: band level computation
// Takes one job at a time, forms the weighted sum, extracts its square root
// one bit per cycle, scales, truncates and saturates it, and holds the result for pop.
// ----------------------------------------------------------------------------
module lbsg_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_empty,
	input  lbsg_pkg::job_t                      job_data,
	output logic                                job_pop,
	input  logic                                pop,
	output logic                                empty,
	output logic [lbsg_pkg::BAND_W-1:0]         band_number,
	output logic signed [lbsg_pkg::LEVEL_W-1:0] band_level,
	output logic                                final_band
);

	lbsg_pkg::back_state_t state_q;
	lbsg_pkg::back_state_t state_d;
	logic [lbsg_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic                       load_out;

	logic [lbsg_pkg::BAND_W-1:0] band_q;
	logic                        last_q;
	logic [lbsg_pkg::SUM_W-1:0]  sum_q;
	logic [lbsg_pkg::INV_W-1:0]  inv_q;
	logic [lbsg_pkg::RAD_W-1:0]  rad_q;
	logic [lbsg_pkg::REM_W-1:0]  rem_q;
	logic [lbsg_pkg::ROOT_W-1:0] root_q;
	logic [lbsg_pkg::Q_W-1:0]    q_q;
	logic                        neg_q;

	logic [lbsg_pkg::PROD_W-1:0]  prod;
	logic [lbsg_pkg::REM_W+1:0]   rem_sh;
	logic [lbsg_pkg::REM_W+1:0]   trial;
	logic [lbsg_pkg::T_W-1:0]     t_val;
	logic [lbsg_pkg::T_W-1:0]     t_mag;
	logic [26:0]                  quot;
	logic [8:0]                   y9;
	logic signed [lbsg_pkg::LEVEL_W-1:0] level;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbsg_pkg::BK_IDLE: begin
				if (!job_empty)
					state_d = lbsg_pkg::BK_MUL;
			end
			lbsg_pkg::BK_MUL: state_d = lbsg_pkg::BK_ROOT;
			lbsg_pkg::BK_ROOT: begin
				if (cnt_q == '0)
					state_d = lbsg_pkg::BK_SCALE;
			end
			lbsg_pkg::BK_SCALE: state_d = lbsg_pkg::BK_EMIT;
			lbsg_pkg::BK_EMIT: begin
				if (!out_valid_q || pop)
					state_d = lbsg_pkg::BK_IDLE;
			end
			default: state_d = lbsg_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			lbsg_pkg::BK_IDLE: job_pop = !job_empty;
			lbsg_pkg::BK_EMIT: load_out = !out_valid_q || pop;
			default: begin
				job_pop = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_comb begin
		prod = lbsg_pkg::PROD_W'(sum_q) * lbsg_pkg::PROD_W'(inv_q);
		rem_sh = {rem_q, rad_q[lbsg_pkg::RAD_W-1 -: 2]};
		trial = (lbsg_pkg::REM_W + 2)'({root_q, 2'b01});
		t_val = (lbsg_pkg::T_W'(root_q) << 11) + (lbsg_pkg::T_W'(root_q) << 7);
		if (t_val >= lbsg_pkg::FOUR_D)
			t_mag = t_val - lbsg_pkg::FOUR_D;
		else
			t_mag = lbsg_pkg::FOUR_D - t_val;
		quot = 27'(q_q[10:0]) * 27'(lbsg_pkg::RECIP_5);
		y9 = quot[26:18];
		if (neg_q)
			level = -$signed({1'b0, y9});
		else if (q_q >= lbsg_pkg::SAT_Q)
			level = 10'sd256;
		else
			level = $signed({1'b0, y9});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbsg_pkg::BK_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lbsg_pkg::BK_MUL)
				cnt_q <= lbsg_pkg::CNT_W'(lbsg_pkg::ROOT_STEPS - 1);
			else if (state_q == lbsg_pkg::BK_ROOT)
				cnt_q <= cnt_q - lbsg_pkg::CNT_W'(1);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lbsg_pkg::BK_IDLE: begin
				band_q <= job_data.band;
				last_q <= job_data.last;
				sum_q <= job_data.sum;
				inv_q <= job_data.inv;
			end
			lbsg_pkg::BK_MUL: begin
				rad_q <= {1'b0, prod, 16'd0};
				rem_q <= '0;
				root_q <= '0;
			end
			lbsg_pkg::BK_ROOT: begin
				rad_q <= rad_q << 2;
				if (rem_sh >= trial) begin
					rem_q <= lbsg_pkg::REM_W'(rem_sh - trial);
					root_q <= {root_q[lbsg_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= lbsg_pkg::REM_W'(rem_sh);
					root_q <= {root_q[lbsg_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			lbsg_pkg::BK_SCALE: begin
				q_q <= t_mag[lbsg_pkg::T_W-1 -: lbsg_pkg::Q_W];
				neg_q <= t_val < lbsg_pkg::FOUR_D;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			band_number <= band_q;
			band_level <= level;
			final_band <= last_q;
		end
	end

	assign empty = !out_valid_q;

	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lbsg_pkg::BK_ROOT && cnt_q == '0 |=> state_q == lbsg_pkg::BK_SCALE)
		else $error("Square root did not finish after its last step.");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> band_level >= -10'sd4 && band_level <= 10'sd256)
		else $error("Band level outside its range.");

endmodule
